>>> rtl/page_frame_allocator_defines.svh
// assertion macros for the page frame allocator
`ifndef PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define PFA_ASSERT_IMP(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("page frame allocator: implication failed");

// next-cycle implication, disabled during reset
`define PFA_ASSERT_NXT(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("page frame allocator: next-cycle implication failed");

`else

`define PFA_ASSERT_IMP(label, c, r, ante, cons)
`define PFA_ASSERT_NXT(label, c, r, ante, cons)

`endif

`endif

>>> rtl/pfa_pkg.sv
package pfa_pkg;

    // default geometry
    localparam int unsigned PAGE_COUNT_DEF     = 1024;
    localparam int unsigned RESERVED_PAGES_DEF = 256;
    localparam int unsigned PAGE_SHIFT_DEF     = 12;

    // free bitmap row geometry
    localparam int unsigned ROW_W  = 32;
    localparam int unsigned ROW_SH = 5;

    // use count values
    localparam logic [7:0] COUNT_FREE   = 8'd0;
    localparam logic [7:0] COUNT_ONE    = 8'd1;
    localparam logic [7:0] COUNT_LOCKED = 8'hFF;

    // request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] RS_OK    = 2'd0;
    localparam logic [1:0] RS_OOM   = 2'd1;
    localparam logic [1:0] RS_RANGE = 2'd2;
    localparam logic [1:0] RS_FREE  = 2'd3;

    typedef struct packed {
        logic        func;
        logic [31:0] phys_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page_addr;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FREE_RD,
        S_FREE_UPD,
        S_DONE
    } state_t;

endpackage

>>> rtl/page_frame_allocator.sv
// channel  | valid      | stall      | payload
// ---------+------------+------------+----------------------------------
// request  | req_valid  | req_stall  | req : func, phys_addr
// response | rsp_valid  | rsp_stall  | rsp : status, page_addr
//
// allocate: the search starts at the bitmap row of the search hint and reads
//   further 32-page bitmap rows until a row holds a free page or the last row
//   is read; after a failed search it fails at once until a page is freed;
//   the search runs through one bitmap memory read port and one encoder
// free: a count read, then a count update; an address beyond the last page
//   goes straight to the final step; items are taken one at a time
// reset: a clearing pass writes the locked and free counts and the bitmap; no
//   item is taken meanwhile
// the response register parts the sides; a stalled response holds the block
//   in its last step only if a newer result is ready

`include "page_frame_allocator_defines.svh"

module page_frame_allocator #(
    parameter int unsigned PAGE_COUNT     = pfa_pkg::PAGE_COUNT_DEF,
    parameter int unsigned RESERVED_PAGES = pfa_pkg::RESERVED_PAGES_DEF,
    parameter int unsigned PAGE_SHIFT     = pfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pfa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pfa_pkg::rsp_t rsp
);

    import pfa_pkg::*;

    // reserved pages clipped to the page count
    localparam int unsigned RES_EFF   = (RESERVED_PAGES < PAGE_COUNT) ? RESERVED_PAGES
                                                                      : PAGE_COUNT;
    // lowest page that may be free after reset; page zero is never handed out
    localparam int unsigned HINT_INIT = (RES_EFF > 1) ? RES_EFF : 1;
    // page counter width, holds PAGE_COUNT itself
    localparam int unsigned PIX_W     = $clog2(PAGE_COUNT + 1);
    // count memory address width
    localparam int unsigned IDX_W     = $clog2(PAGE_COUNT);
    // bitmap rows of 32 pages each
    localparam int unsigned ROWS      = (PAGE_COUNT + ROW_W - 1) / ROW_W;
    localparam int unsigned ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    // width for page numbers inside a row during the clearing pass
    localparam int unsigned PW        = PIX_W + ROW_SH;

    // sequencer
    state_t state_reg;
    state_t state_next;

    // clearing pass page counter
    logic [PIX_W-1:0] clr_idx_reg;
    logic [PIX_W-1:0] clr_idx_next;

    // every page in [1, hint) is in use; hint == PAGE_COUNT means none free
    logic [PIX_W-1:0] hint_reg;
    logic [PIX_W-1:0] hint_next;

    // current bitmap row of the search
    logic [ROW_AW-1:0] scan_row_reg;
    logic [ROW_AW-1:0] scan_row_next;

    // page of a free request
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;

    // result being built and the response register
    rsp_t res_reg;
    rsp_t res_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;

    // use count memory
    logic [7:0]       cnt_mem [PAGE_COUNT];
    logic [7:0]       cnt_rd_reg;
    logic             cnt_we;
    logic [IDX_W-1:0] cnt_waddr;
    logic [7:0]       cnt_wdata;
    logic [IDX_W-1:0] cnt_raddr;

    // free page bitmap, one bit per page, set when the count is zero
    logic [ROW_W-1:0]  bm_mem [ROWS];
    logic [ROW_W-1:0]  bm_rd_reg;
    logic              bm_we;
    logic [ROW_AW-1:0] bm_waddr;
    logic [ROW_W-1:0]  bm_wdata;
    logic [ROW_AW-1:0] bm_raddr;

    // helpers
    logic              accept;
    logic              rsp_free;
    logic [31:0]       req_idx;
    logic              req_in_range;
    logic [ROW_W-1:0]  hit_word;
    logic [ROW_SH-1:0] hit_bit;
    logic              row_hit;
    logic [PIX_W-1:0]  found_page;
    logic [31:0]       found_addr;
    logic              last_row;
    logic [ROW_AW-1:0] free_row;
    logic [ROW_SH-1:0] free_bit;
    logic [ROW_W-1:0]  clr_row_bits;

    assign accept       = req_valid && !req_stall;
    assign rsp_free     = !rsp_valid_reg || !rsp_stall;
    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

    // frame index of a free request; low address bits drop out
    assign req_idx      = req.phys_addr >> PAGE_SHIFT;
    assign req_in_range = (req_idx < 32'(PAGE_COUNT));

    assign free_row     = ROW_AW'(free_idx_reg >> ROW_SH);
    assign free_bit     = ROW_SH'(free_idx_reg);
    assign last_row     = (scan_row_reg == ROW_AW'(ROWS - 1));

    // page zero never qualifies
    always_comb
    begin
        hit_word = bm_rd_reg;
        if (scan_row_reg == '0)
        begin
            hit_word[0] = 1'b0;
        end
    end

    // lowest set bit of the row
    always_comb
    begin
        hit_bit = '0;
        for (int j = ROW_W - 1; j >= 0; j--)
        begin
            if (hit_word[j])
            begin
                hit_bit = ROW_SH'(j);
            end
        end
        row_hit = |hit_word;
    end

    assign found_page = PIX_W'({scan_row_reg, hit_bit});
    assign found_addr = 32'(found_page) << PAGE_SHIFT;

    // reset contents of the bitmap row starting at the clearing counter
    always_comb
    begin
        logic [PW-1:0] p;
        p = '0;
        for (int j = 0; j < ROW_W; j++)
        begin
            p = PW'(clr_idx_reg) + PW'(j);
            clr_row_bits[j] = (p >= PW'(RES_EFF)) && (p < PW'(PAGE_COUNT));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == PIX_W'(PAGE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == FUNC_ALLOC)
                    begin
                        state_next = (hint_reg == PIX_W'(PAGE_COUNT)) ? S_DONE : S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = req_in_range ? S_FREE_RD : S_DONE;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                state_next = (row_hit || last_row) ? S_DONE : S_SCAN_RD;
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_UPD;
            end
            S_FREE_UPD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        clr_idx_next   = clr_idx_reg;
        hint_next      = hint_reg;
        scan_row_next  = scan_row_reg;
        free_idx_next  = free_idx_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        cnt_we    = 1'b0;
        cnt_waddr = free_idx_reg;
        cnt_wdata = cnt_rd_reg - COUNT_ONE;
        cnt_raddr = free_idx_reg;

        bm_we    = 1'b0;
        bm_waddr = free_row;
        bm_wdata = bm_rd_reg | (ROW_W'(1) << free_bit);
        bm_raddr = (state_reg == S_FREE_RD) ? free_row : scan_row_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we       = 1'b1;
                cnt_waddr    = IDX_W'(clr_idx_reg);
                cnt_wdata    = (clr_idx_reg < PIX_W'(RES_EFF)) ? COUNT_LOCKED : COUNT_FREE;
                // one row write at the first page of each row
                bm_we        = ((clr_idx_reg & PIX_W'(ROW_W - 1)) == '0);
                bm_waddr     = ROW_AW'(clr_idx_reg >> ROW_SH);
                bm_wdata     = clr_row_bits;
                clr_idx_next = clr_idx_reg + PIX_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.page_addr = '0;
                    if (req.func == FUNC_ALLOC)
                    begin
                        scan_row_next   = ROW_AW'(hint_reg >> ROW_SH);
                        res_next.status = RS_OOM;
                    end
                    else
                    begin
                        free_idx_next   = IDX_W'(req_idx);
                        res_next.status = req_in_range ? RS_OK : RS_RANGE;
                    end
                end
            end
            S_SCAN_RD:
            begin
                // row read issued through bm_raddr
            end
            S_SCAN_CHK:
            begin
                if (row_hit)
                begin
                    bm_we     = 1'b1;
                    bm_waddr  = scan_row_reg;
                    bm_wdata  = bm_rd_reg & ~(ROW_W'(1) << hit_bit);
                    cnt_we    = 1'b1;
                    cnt_waddr = IDX_W'(found_page);
                    cnt_wdata = COUNT_ONE;
                    res_next.status    = RS_OK;
                    res_next.page_addr = found_addr;
                    hint_next = found_page + PIX_W'(1);
                end
                else if (last_row)
                begin
                    hint_next = PIX_W'(PAGE_COUNT);
                end
                else
                begin
                    scan_row_next = scan_row_reg + ROW_AW'(1);
                end
            end
            S_FREE_RD:
            begin
                // count and bitmap row reads issued
            end
            S_FREE_UPD:
            begin
                if (cnt_rd_reg == COUNT_FREE)
                begin
                    res_next.status = RS_FREE;
                end
                else
                begin
                    cnt_we = 1'b1;
                    if (cnt_rd_reg == COUNT_ONE)
                    begin
                        bm_we = 1'b1;
                        if ((free_idx_reg != '0) && (PIX_W'(free_idx_reg) < hint_reg))
                        begin
                            hint_next = PIX_W'(free_idx_reg);
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            hint_reg      <= PIX_W'(HINT_INIT);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            hint_reg      <= hint_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_row_reg <= scan_row_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    // use count memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    // free bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_rd_reg <= bm_mem[bm_raddr];
    end

    // search hint stays within page one and the page count
    `PFA_ASSERT_IMP(a_hint_range, clk, rst_n, 1'b1,
                    (hint_reg != '0) && (hint_reg <= PIX_W'(PAGE_COUNT)))

    // a bitmap hit never names a page beyond the last one
    `PFA_ASSERT_IMP(a_found_in_range, clk, rst_n, (state_reg == S_SCAN_CHK) && row_hit,
                    found_page < PIX_W'(PAGE_COUNT))

    // a new response only comes out of the final step
    `PFA_ASSERT_IMP(a_rsp_from_done, clk, rst_n, $rose(rsp_valid),
                    $past(state_reg) == S_DONE)

    // an allocate either starts the search or fails at once
    `PFA_ASSERT_NXT(a_alloc_start, clk, rst_n, accept && (req.func == FUNC_ALLOC),
                    (state_reg == S_SCAN_RD) || (state_reg == S_DONE))

endmodule

>>> verif/page_frame_allocator_tb.sv
module page_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    // block geometry, kept at the package defaults
    localparam int unsigned PAGE_COUNT     = PAGE_COUNT_DEF;
    localparam int unsigned RESERVED_PAGES = RESERVED_PAGES_DEF;
    localparam int unsigned PAGE_SHIFT     = PAGE_SHIFT_DEF;
    localparam logic [31:0] LOW_MASK       = (32'd1 << PAGE_SHIFT) - 32'd1;

    // clearing pass after reset plus the slowest allocate and both idle draws
    localparam int unsigned QUIET_LIMIT   = 5000;
    // settle time once the last result is in, covers a full bitmap scan
    localparam int unsigned SETTLE_CYCLES = 120;
    localparam int unsigned REPORT_CAP    = 50;
    // random items after the directed table
    localparam int unsigned RANDOM_ITEMS  = 1782;

    // one row of the directed table: request, whether the result is typed in, result
    typedef struct packed {
        req_t item;
        logic typed;
        rsp_t want;
    } probe_t;

    localparam int unsigned PROBE_ROWS = 18;
    localparam probe_t DIRECTED [PROBE_ROWS] = '{
        // first fit after reset lands on the first page above the reserved block
        '{'{FUNC_ALLOC, 32'h0000_0000}, 1'b1, '{RS_OK, 32'h0010_0000}},
        // address field is ignored on allocate
        '{'{FUNC_ALLOC, 32'hFFFF_FFFF}, 1'b1, '{RS_OK, 32'h0010_1000}},
        '{'{FUNC_FREE,  32'h0010_0000}, 1'b1, '{RS_OK, 32'h0000_0000}},
        // low address bits ignored, page already free
        '{'{FUNC_FREE,  32'h0010_0FFF}, 1'b1, '{RS_FREE, 32'h0000_0000}},
        // freed page is reused first
        '{'{FUNC_ALLOC, 32'h0000_0000}, 1'b1, '{RS_OK, 32'h0010_0000}},
        // one page past the end
        '{'{FUNC_FREE,  32'h0040_0000}, 1'b1, '{RS_RANGE, 32'h0000_0000}},
        '{'{FUNC_FREE,  32'hFFFF_FFFF}, 1'b1, '{RS_RANGE, 32'h0000_0000}},
        // last page, never allocated
        '{'{FUNC_FREE,  32'h003F_FFFF}, 1'b1, '{RS_FREE, 32'h0000_0000}},
        // locked pages just count down, page zero and the top reserved one
        '{'{FUNC_FREE,  32'h0000_0000}, 1'b1, '{RS_OK, 32'h0000_0000}},
        '{'{FUNC_FREE,  32'h000F_F123}, 1'b1, '{RS_OK, 32'h0000_0000}},
        '{'{FUNC_FREE,  32'h0010_1ABC}, 1'b1, '{RS_OK, 32'h0000_0000}},
        '{'{FUNC_FREE,  32'h0010_1000}, 1'b1, '{RS_FREE, 32'h0000_0000}},
        '{'{FUNC_ALLOC, 32'h1234_5678}, 1'b1, '{RS_OK, 32'h0010_1000}},
        // alternating bit patterns, both far out of range
        '{'{FUNC_FREE,  32'hAAAA_AAAA}, 1'b1, '{RS_RANGE, 32'h0000_0000}},
        '{'{FUNC_FREE,  32'h5555_5555}, 1'b1, '{RS_RANGE, 32'h0000_0000}},
        // left to the predictor from here
        '{'{FUNC_FREE,  32'h003F_F000}, 1'b0, '{RS_OK, 32'h0000_0000}},
        '{'{FUNC_ALLOC, 32'h0000_0000}, 1'b0, '{RS_OK, 32'h0000_0000}},
        '{'{FUNC_FREE,  32'h0000_0FFF}, 1'b0, '{RS_OK, 32'h0000_0000}}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // predicted use count per page and pages handed out that may be freed later
    logic [7:0]  page_use [PAGE_COUNT];
    int unsigned held_pages[$];
    rsp_t        pending_results[$];
    rsp_t        oldest_result;
    int unsigned mismatch_count = 0;

    // idle modes: when set that side runs with no gaps for a stretch
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    int unsigned rsp_hold   = 0;

    page_frame_allocator #(
        .PAGE_COUNT     (PAGE_COUNT),
        .RESERVED_PAGES (RESERVED_PAGES),
        .PAGE_SHIFT     (PAGE_SHIFT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_CAP)
            $display("%0t ns mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic int unsigned draw_wait(input bit burst);
        if (burst || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(1, 18);
    endfunction

    // first fit from page one, or count down the addressed page
    function automatic rsp_t predict_allocation(input req_t item);
        rsp_t        result;
        logic [31:0] page_idx;
        result.status    = RS_OK;
        result.page_addr = '0;
        if (item.func == FUNC_ALLOC)
        begin
            result.status = RS_OOM;
            for (int unsigned i = 1; i < PAGE_COUNT; i++)
            begin
                if (page_use[i] == COUNT_FREE)
                begin
                    page_use[i]      = COUNT_ONE;
                    result.status    = RS_OK;
                    result.page_addr = 32'(64'(i) << PAGE_SHIFT);
                    held_pages.push_back(i);
                    break;
                end
            end
        end
        else
        begin
            page_idx = item.phys_addr >> PAGE_SHIFT;
            if (page_idx >= PAGE_COUNT)
                result.status = RS_RANGE;
            else if (page_use[page_idx] == COUNT_FREE)
                result.status = RS_FREE;
            else
                page_use[page_idx] = page_use[page_idx] - 8'd1;
        end
        return result;
    endfunction

    function automatic req_t make_alloc();
        req_t item;
        item.func      = FUNC_ALLOC;
        item.phys_addr = $urandom;
        return item;
    endfunction

    // free request for a page, with random offset bits below the page size
    function automatic req_t make_free(input int unsigned page_idx);
        req_t item;
        item.func      = FUNC_FREE;
        item.phys_addr = 32'(64'(page_idx) << PAGE_SHIFT) | (32'($urandom) & LOW_MASK);
        return item;
    endfunction

    // mostly well-formed traffic: allocates and frees of held pages, the rest
    // double frees, frees of locked pages and wild addresses
    function automatic req_t random_request(input int unsigned alloc_pct);
        req_t        item;
        int unsigned roll;
        int unsigned pick;
        int unsigned page_idx;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
            return make_alloc();
        roll = $urandom_range(0, 99);
        if (roll < 55 && held_pages.size() != 0)
        begin
            pick     = $urandom_range(0, held_pages.size() - 1);
            page_idx = held_pages[pick];
            held_pages.delete(pick);
            item = make_free(page_idx);
        end
        else if (roll < 75)
            item = make_free($urandom_range(0, PAGE_COUNT - 1));
        else if (roll < 90)
        begin
            item.func      = FUNC_FREE;
            item.phys_addr = $urandom;
        end
        else
            item = make_free($urandom_range(0, RESERVED_PAGES - 1));
        return item;
    endfunction

    // presents one item, holds it while stalled, predicts on acceptance
    task automatic issue_request(input req_t item, input bit typed, input rsp_t want);
        int unsigned gap;
        rsp_t        predicted;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = draw_wait(send_burst);
        // valid only drops when a gap follows, never lowered and raised in one step
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted = predict_allocation(item);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // result side: check each accepted item, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with nothing pending, status %0d addr %h",
                                          rsp.status, rsp.page_addr));
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp.status !== oldest_result.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp.status, oldest_result.status));
                if (rsp.page_addr !== oldest_result.page_addr)
                    report_mismatch($sformatf("page_addr %h, expected %h",
                                              rsp.page_addr, oldest_result.page_addr));
            end
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            rsp_hold = draw_wait(recv_burst);
        end
        else if (rsp_hold != 0)
            rsp_hold--;
        rsp_stall <= (rsp_hold != 0);
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned alloc_pct;
        // predicted counts start from the reset contents
        for (int unsigned i = 0; i < PAGE_COUNT; i++)
            page_use[i] = (i < RESERVED_PAGES) ? COUNT_LOCKED : COUNT_FREE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int unsigned r = 0; r < PROBE_ROWS; r++)
            issue_request(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);

        // random part: fill, run out of pages, drain, then mixed traffic
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < 1000)
                alloc_pct = 80;
            else if (n < 1300)
                alloc_pct = 95;
            else if (n < 1600)
                alloc_pct = 10;
            else
                alloc_pct = 50;
            issue_request(random_request(alloc_pct), 1'b0, '0);
        end
        req_valid <= 1'b0;

        // wait for the outstanding results, then for anything stray
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> page_frame_allocator.f
+incdir+rtl
rtl/pfa_pkg.sv
rtl/page_frame_allocator.sv
verif/page_frame_allocator_tb.sv
